// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: src/nnct_pkg.sv
// ----------------------------------------------------------------------------
// nnct_pkg
// Shared types and constants of the NHWC to NCHW corner turn.
// ----------------------------------------------------------------------------
`default_nettype none

package nnct_pkg;

  localparam int DATA_W     = 32;
  localparam int CHAN_CFG_W = 9;
  localparam int POS_CFG_W  = 5;
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [CHAN_CFG_W-1:0] CHAN_CFG_RESET = 9'd256;
  localparam logic [POS_CFG_W-1:0]  POS_CFG_RESET  = 5'd9;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_CHANNELS  = 1'b0,
    REG_POSITIONS = 1'b1
  } reg_idx_t;

  // per-item control from the address generator
  typedef struct packed {
    logic emit;       // a previous batch is stored, this item yields a result
    logic batch_end;  // this item closes the input batch
  } step_ctrl_t;

  // one result item as held in the output queue
  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              last;
  } out_entry_t;

endpackage

`default_nettype wire

// File: src/nnct_if.sv
// ----------------------------------------------------------------------------
// nnct_if
// Valid/ready stream interfaces for input and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnct_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface nnct_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word;
  logic        last_of_batch;

  modport source (output valid, output out_word, output last_of_batch, input ready);
  modport sink   (input valid, input out_word, input last_of_batch, output ready);
endinterface

`default_nettype wire

// File: src/nhwc_to_nchw_corner_turn.sv
// ----------------------------------------------------------------------------
// nhwc_to_nchw_corner_turn
// Streaming NHWC to NCHW layout converter with two ping-pong banks.
// ----------------------------------------------------------------------------
// Usage:
//   nhwc  : input items, one 32-bit element each, channel fastest (NHWC).
//   nchw  : result items, the previous batch in NCHW order; last_of_batch
//           flags its final element.
//   APB   : reg 0 (addr 0) channels_in_use, reg 1 (addr 4) positions_in_use.
//           Write only while the block is idle. pready is tied high.
// Each accepted item is written into the active bank while, once a batch is
// stored, one word of the other bank is read linearly. Banks swap as the
// last item of a batch is accepted. The first batch yields no result items.
// Throughput: one item per cycle in and out while the result queue has
// room, set by the single write and single read port of the bank RAM
// (2*MAX_CHANNELS*MAX_POSITIONS words). An accepted item that causes a
// result launches a registered RAM read, whose word is then registered
// into the result queue before it is valid on nchw.
// Stall: a three-entry queue absorbs RAM reads in flight; nhwc.ready drops
// only when all queue slots are taken or reserved.
// Reset: counters cleared, bank 0 active, no stored batch, queue empty,
// sizes back to 256 channels and 9 positions. RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nhwc_to_nchw_corner_turn import nnct_pkg::*; #(
  parameter int MAX_CHANNELS  = 256,
  parameter int MAX_POSITIONS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  nnct_in_if.sink                    nhwc,
  nnct_out_if.source                 nchw,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int BANK_WORDS = MAX_CHANNELS * MAX_POSITIONS;
  localparam int MW         = $clog2(2 * BANK_WORDS);

  // configuration registers (raw values, clamped in the address generator)
  logic [CHAN_CFG_W-1:0] channels_in_use;
  logic [POS_CFG_W-1:0]  positions_in_use;
  reg_idx_t              reg_idx;
  logic                  cfg_write;

  step_ctrl_t            ctrl;
  logic [MW-1:0]         wr_mem_addr;
  logic [MW-1:0]         rd_mem_addr;
  logic [DATA_W-1:0]     rd_word;
  logic                  fire;
  logic                  issue;
  logic                  can_issue;

  // ---- APB register port ----
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_CHANNELS:  prdata = APB_DATA_W'(channels_in_use);
      REG_POSITIONS: prdata = APB_DATA_W'(positions_in_use);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use  <= CHAN_CFG_RESET;
      positions_in_use <= POS_CFG_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_CHANNELS:  channels_in_use  <= pwdata[CHAN_CFG_W-1:0];
        REG_POSITIONS: positions_in_use <= pwdata[POS_CFG_W-1:0];
      endcase
    end
  end

  // ---- input handshake ----
  // every item waits for a free queue slot; only result items reserve one
  assign nhwc.ready = can_issue;
  assign fire       = nhwc.valid && nhwc.ready;
  assign issue      = fire && ctrl.emit;

  nnct_addr_gen #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_addr_gen (
    .clk         (clk),
    .rst         (rst),
    .chan_cfg    (channels_in_use),
    .pos_cfg     (positions_in_use),
    .advance     (fire),
    .ctrl        (ctrl),
    .wr_mem_addr (wr_mem_addr),
    .rd_mem_addr (rd_mem_addr)
  );

  // both banks in one RAM; write and read always hit opposite banks
  nnct_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * BANK_WORDS)
  ) u_bank_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (wr_mem_addr),
    .wdata (nhwc.data_word),
    .re    (issue),
    .raddr (rd_mem_addr),
    .rdata (rd_word)
  );

  nnct_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_last (ctrl.batch_end),
    .rd_word    (rd_word),
    .can_issue  (can_issue),
    .outq       (nchw)
  );

endmodule

`default_nettype wire

// File: src/nnct_ram.sv
// ----------------------------------------------------------------------------
// nnct_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nnct_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 8192,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/nnct_addr_gen.sv
// ----------------------------------------------------------------------------
// nnct_addr_gen
// Channel/position counters, strided write address and linear read address.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nnct_addr_gen import nnct_pkg::*; #(
  parameter  int MAX_CHANNELS  = 256,
  parameter  int MAX_POSITIONS = 16,
  localparam int BANK_WORDS    = MAX_CHANNELS * MAX_POSITIONS,
  localparam int MW            = $clog2(2 * BANK_WORDS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CHAN_CFG_W-1:0] chan_cfg,
  input  wire logic [POS_CFG_W-1:0]  pos_cfg,
  input  wire logic                  advance,
  output step_ctrl_t                 ctrl,
  output logic      [MW-1:0]         wr_mem_addr,
  output logic      [MW-1:0]         rd_mem_addr
);

  localparam int AW  = (BANK_WORDS > 1) ? $clog2(BANK_WORDS) : 1;
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int CXW = (CW + 1 > CHAN_CFG_W) ? CW + 1 : CHAN_CFG_W;
  localparam int PXW = (PW + 1 > POS_CFG_W) ? PW + 1 : POS_CFG_W;

  logic          write_bank;
  logic [CW-1:0] channel_count;
  logic [PW-1:0] position_count;
  logic [AW-1:0] write_address;
  logic [AW-1:0] read_address;
  logic          prev_ready;

  logic [CXW-1:0] chan_ext;
  logic [PXW-1:0] pos_ext;
  logic [CW-1:0]  chan_last;
  logic [PW-1:0]  pos_last;
  logic [PW:0]    pos_size;
  logic           channel_wrap;
  logic           batch_end;
  logic [AW:0]    wa_sum;
  logic [AW-1:0]  wa_stride;
  logic [AW-1:0]  ra_inc;

  // clamp sizes: zero counts as one, above max saturates
  assign chan_ext = CXW'(chan_cfg);
  assign pos_ext  = PXW'(pos_cfg);

  always_comb begin
    if (chan_ext == '0) begin
      chan_last = '0;
    end else if (chan_ext > CXW'(MAX_CHANNELS)) begin
      chan_last = CW'(MAX_CHANNELS - 1);
    end else begin
      chan_last = CW'(chan_ext - CXW'(1));
    end
    if (pos_ext == '0) begin
      pos_last = '0;
    end else if (pos_ext > PXW'(MAX_POSITIONS)) begin
      pos_last = PW'(MAX_POSITIONS - 1);
    end else begin
      pos_last = PW'(pos_ext - PXW'(1));
    end
  end

  assign pos_size     = {1'b0, pos_last} + (PW+1)'(1);
  assign channel_wrap = channel_count >= chan_last;
  assign batch_end    = channel_wrap && (position_count >= pos_last);

  // next channel: step by the position count, wrap modulo bank size
  assign wa_sum    = {1'b0, write_address} + (AW+1)'(pos_size);
  assign wa_stride = (wa_sum >= (AW+1)'(BANK_WORDS)) ?
                     AW'(wa_sum - (AW+1)'(BANK_WORDS)) : AW'(wa_sum);
  assign ra_inc    = (read_address == AW'(BANK_WORDS - 1)) ?
                     '0 : read_address + AW'(1);

  assign ctrl.emit      = prev_ready;
  assign ctrl.batch_end = batch_end;

  // bank select offsets the flat RAM address
  assign wr_mem_addr = write_bank ? MW'(write_address) + MW'(BANK_WORDS)
                                  : MW'(write_address);
  assign rd_mem_addr = write_bank ? MW'(read_address)
                                  : MW'(read_address) + MW'(BANK_WORDS);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank     <= 1'b0;
      channel_count  <= '0;
      position_count <= '0;
      write_address  <= '0;
      read_address   <= '0;
      prev_ready     <= 1'b0;
    end else if (advance) begin
      if (batch_end) begin
        channel_count  <= '0;
        position_count <= '0;
        write_address  <= '0;
        read_address   <= '0;
        write_bank     <= ~write_bank;
        prev_ready     <= 1'b1;
      end else begin
        read_address <= ra_inc;
        if (channel_wrap) begin
          channel_count  <= '0;
          position_count <= position_count + PW'(1);
          write_address  <= AW'(position_count + PW'(1));
        end else begin
          channel_count <= channel_count + CW'(1);
          write_address <= wa_stride;
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_wa_range, clk, rst, {1'b0, write_address} < (AW+1)'(BANK_WORDS))
  `ASSERT_NEXT(a_bank_swap, clk, rst, advance && batch_end, write_bank != $past(write_bank))
  `ASSERT_NEXT(a_ready_sticks, clk, rst, prev_ready, prev_ready)
  `ASSERT_NEXT(a_batch_restart, clk, rst, advance && batch_end,
               channel_count == '0 && position_count == '0 && read_address == '0)

endmodule

`default_nettype wire

// File: src/nnct_out_queue.sv
// ----------------------------------------------------------------------------
// nnct_out_queue
// Three-entry result queue behind the RAM read port, with issue credit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nnct_out_queue import nnct_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              issue,      // RAM read launched this cycle
  input  wire logic              issue_last,
  input  wire logic [DATA_W-1:0] rd_word,    // RAM data, valid in the cycle after issue
  output logic                   can_issue,
  nnct_out_if.source             outq
);

  localparam int QDEPTH = 3;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  out_entry_t     entries [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           pending;
  logic           pending_last;
  logic           push;
  logic           pop;

  assign push = pending;
  assign pop  = outq.valid && outq.ready;

  // a slot is reserved for every read still in flight
  assign can_issue = ({1'b0, count} + (QCW+1)'(pending)) < (QCW+1)'(QDEPTH);

  assign outq.valid         = count != '0;
  assign outq.out_word      = entries[rd_ptr].word;
  assign outq.last_of_batch = entries[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{word: rd_word, last: pending_last};
    end
    if (issue) begin
      pending_last <= issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      pending <= 1'b0;
    end else begin
      pending <= issue;
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + QPW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_issue_credit, clk, rst, issue, can_issue)
  `ASSERT_ALWAYS(a_no_overflow, clk, rst,
                 ({1'b0, count} + (QCW+1)'(pending)) <= (QCW+1)'(QDEPTH))
  `ASSERT_NEXT(a_push_visible, clk, rst, pending, count != '0)

endmodule

`default_nettype wire
